/* hw/rtl/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the call latency tracker.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int TID_W    = 22;
  localparam int PID_W    = 22;
  localparam int CID_IN_W = 11;
  localparam int CID_W    = 10;  // stored call id, wide enough for any non-negative input call id
  localparam int CNUM_W   = 9;
  localparam int TS_W     = 64;
  localparam int CNT_W    = 48;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 22;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_PROC_ON  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALL_ON  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALL_VAL = 8'd3;

  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_UPDATE
  } clt_state_t;

  // broadcast from the controller to every slot cell
  typedef struct packed {
    logic enter_wr;  // matching cell takes the new call
    logic alloc;     // first free cell opens a slot
    logic retire;    // matching cell closes
  } clt_ctrl_t;

  typedef struct packed {
    logic [CID_W-1:0] call;
    logic [TS_W-1:0]  start;
    logic [TS_W-1:0]  addr;
  } clt_slot_t;

  typedef struct packed {
    logic [CNT_W-1:0] done;
    logic [CNT_W-1:0] lost;
    logic [TS_W-1:0]  sum;
  } clt_stat_t;

endpackage

/* hw/rtl/clt_cell.sv */
// ----------------------------------------------------------------------------
// clt_cell
// One open-call slot; passes free, hit and read data on to its neighbor.
// ----------------------------------------------------------------------------
module clt_cell
  import clt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  clt_ctrl_t        ctrl,
  input  logic [TID_W-1:0] tid,
  input  clt_slot_t        wr_data,
  input  logic             free_in,
  input  logic             hit_in,
  input  clt_slot_t        rd_in,
  output logic             free_out,
  output logic             hit_out,
  output clt_slot_t        rd_out
);

  logic             valid_r;
  logic [TID_W-1:0] thread_r;
  clt_slot_t        data_r;
  logic             match;
  logic             first_free;

  assign match      = valid_r && (thread_r == tid);
  assign first_free = !valid_r && !free_in;
  assign free_out   = free_in | !valid_r;
  assign hit_out    = hit_in | match;
  assign rd_out     = match ? data_r : rd_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.alloc && first_free) begin
      valid_r <= 1'b1;
    end else if (ctrl.retire && match) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.enter_wr && match) || (ctrl.alloc && first_free)) begin
      data_r <= wr_data;
    end
    if (ctrl.alloc && first_free) begin
      thread_r <= tid;
    end
  end

endmodule

/* hw/rtl/call_latency_tracker.sv */
// ----------------------------------------------------------------------------
// call_latency_tracker
// Enter/exit latency monitor: a chain of thread slot cells plus a per-call
// statistics memory updated by read-modify-write.
// ----------------------------------------------------------------------------
// A word passes slot search, then statistics update for a record; an output
//   stall holds the update. Input waits during a record's search; a word
//   that makes no record frees the input during its search. The statistics
//   memory port is the limit: one read per word and one write per record.
// Reset: synchronous, active low; slots empty, registers zero, then a pass
//   over all NUM_CALLS entries zeroes statistics memory before input opens.
module call_latency_tracker
  import clt_pkg::*;
#(
  parameter int THREAD_SLOTS = 64,
  parameter int NUM_CALLS    = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [TID_W-1:0]     in_thread_id,
  input  logic [PID_W-1:0]     in_process_id,
  input  logic [CID_IN_W-1:0]  in_call_id,
  input  logic [TS_W-1:0]      in_timestamp_ns,
  input  logic [TS_W-1:0]      in_instr_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CNUM_W-1:0]    out_call_number,
  output logic                 out_completed,
  output logic [TS_W-1:0]      out_duration_ns,
  output logic [CNT_W-1:0]     out_completed_count,
  output logic [CNT_W-1:0]     out_unresolved_total,
  output logic [TS_W-1:0]      out_total_time_ns,
  output logic [PID_W-1:0]     out_report_process,
  output logic [TS_W-1:0]      out_report_addr,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = (NUM_CALLS > 1) ? $clog2(NUM_CALLS) : 1;
  localparam logic [AW-1:0] LAST_CALL = AW'(NUM_CALLS - 1);

  // configuration
  logic             pf_on_r;
  logic [PID_W-1:0] pf_val_r;
  logic             cf_on_r;
  logic [CNUM_W-1:0] cf_val_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_on_r  <= 1'b0;
      pf_val_r <= '0;
      cf_on_r  <= 1'b0;
      cf_val_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROC_ON:  pf_on_r  <= cfg_data[0];
        REG_PROC_VAL: pf_val_r <= cfg_data[PID_W-1:0];
        REG_CALL_ON:  cf_on_r  <= cfg_data[0];
        REG_CALL_VAL: cf_val_r <= cfg_data[CNUM_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  clt_state_t state_r, state_nxt;
  logic       in_acc;
  logic       record;
  logic       out_free;
  logic [AW-1:0] clr_r;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_r == LAST_CALL) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (record) state_nxt = ST_UPDATE;
        else if (!in_acc) state_nxt = ST_IDLE;
      end
      ST_UPDATE: begin
        if (out_free) state_nxt = in_acc ? ST_DECIDE : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_DECIDE: in_ready = !record;
      ST_UPDATE: in_ready = out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  // hold the accepted word
  logic                kind_r;
  logic [TID_W-1:0]    tid_r;
  logic [PID_W-1:0]    pid_r;
  logic [CID_IN_W-1:0] cid_r;
  logic [TS_W-1:0]     ts_r;
  logic [TS_W-1:0]     addr_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      tid_r  <= in_thread_id;
      pid_r  <= in_process_id;
      cid_r  <= in_call_id;
      ts_r   <= in_timestamp_ns;
      addr_r <= in_instr_addr;
    end
  end

  // decide: filters and slot chain
  logic      neg, pf_ok, enter_ok, exit_ok, hit, decide;
  logic [CID_W-1:0] c_fix;
  clt_ctrl_t ctrl;
  clt_slot_t wr_data;
  clt_slot_t rd;

  logic      free_ch [THREAD_SLOTS+1];
  logic      hit_ch  [THREAD_SLOTS+1];
  clt_slot_t rd_ch   [THREAD_SLOTS+1];

  assign decide = (state_r == ST_DECIDE);
  assign neg    = cid_r[CID_IN_W-1];
  assign pf_ok  = !pf_on_r || (pid_r == pf_val_r);

  assign enter_ok = (kind_r == KIND_ENTER) && pf_ok && !neg
                  && !(cf_on_r && (cid_r != {2'b00, cf_val_r}))
                  && (32'(cid_r) < NUM_CALLS);

  assign free_ch[0] = 1'b0;
  assign hit_ch[0]  = 1'b0;
  assign rd_ch[0]   = '0;
  assign hit        = hit_ch[THREAD_SLOTS];
  assign rd         = rd_ch[THREAD_SLOTS];

  // a stored call id out of range maps to call zero
  assign c_fix   = (32'(rd.call) >= NUM_CALLS) ? '0 : rd.call;
  assign exit_ok = (kind_r == KIND_EXIT) && pf_ok && hit
                 && !(cf_on_r && (c_fix != {1'b0, cf_val_r}));
  assign record  = (enter_ok && hit) || exit_ok;

  assign ctrl.enter_wr = decide && enter_ok;
  assign ctrl.alloc    = decide && enter_ok && !hit;
  assign ctrl.retire   = decide && exit_ok;

  assign wr_data.call  = cid_r[CID_W-1:0];
  assign wr_data.start = ts_r;
  assign wr_data.addr  = addr_r;

  for (genvar i = 0; i < THREAD_SLOTS; i++) begin : g_cell
    clt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .tid      (tid_r),
      .wr_data  (wr_data),
      .free_in  (free_ch[i]),
      .hit_in   (hit_ch[i]),
      .rd_in    (rd_ch[i]),
      .free_out (free_ch[i+1]),
      .hit_out  (hit_ch[i+1]),
      .rd_out   (rd_ch[i+1])
    );
  end

  // record fields carried into the update cycle
  logic [CID_W-1:0] s2_call_r;
  logic             s2_done_r;
  logic [TS_W-1:0]  s2_dur_r;
  logic [PID_W-1:0] s2_pid_r;
  logic [TS_W-1:0]  s2_addr_r;

  always_ff @(posedge clk) begin
    if (decide) begin
      s2_call_r <= c_fix;
      s2_done_r <= exit_ok;
      s2_dur_r  <= exit_ok ? (ts_r - rd.start) : '0;
      s2_pid_r  <= pid_r;
      s2_addr_r <= exit_ok ? rd.addr : addr_r;
    end
  end

  // per-call statistics memory
  clt_stat_t stat_mem [NUM_CALLS];
  clt_stat_t stat_rd_r;
  clt_stat_t stat_new;
  logic      upd;

  assign upd = (state_r == ST_UPDATE) && out_free;

  always_comb begin
    stat_new = stat_rd_r;
    if (s2_done_r) begin
      if (stat_rd_r.done != CNT_MAX) stat_new.done = stat_rd_r.done + CNT_W'(1);
      stat_new.sum = stat_rd_r.sum + s2_dur_r;
    end else if (stat_rd_r.lost != CNT_MAX) begin
      stat_new.lost = stat_rd_r.lost + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      stat_mem[clr_r] <= '0;
    end else if (upd) begin
      stat_mem[s2_call_r[AW-1:0]] <= stat_new;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) stat_rd_r <= stat_mem[c_fix[AW-1:0]];
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_call_number      <= s2_call_r[CNUM_W-1:0];
      out_completed        <= s2_done_r;
      out_duration_ns      <= s2_dur_r;
      out_completed_count  <= stat_new.done;
      out_unresolved_total <= stat_new.lost;
      out_total_time_ns    <= stat_new.sum;
      out_report_process   <= s2_pid_r;
      out_report_addr      <= s2_addr_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/clt_checker.sv */
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks for the call latency tracker.
// ----------------------------------------------------------------------------
module clt_checker
  import clt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_completed,
  input logic [TS_W-1:0]  out_duration_ns,
  input logic [CNT_W-1:0] out_completed_count,
  input logic [CNT_W-1:0] out_unresolved_total,
  input logic [CNUM_W-1:0] out_call_number
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_call_number))
    else $error("result word dropped or changed while stalled");

  a_unres_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_completed |-> out_duration_ns == '0)
    else $error("unresolved record with nonzero duration");

  a_done_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_completed |-> out_completed_count != '0)
    else $error("completed record with zero count");

  a_lost_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_completed |-> out_unresolved_total != '0)
    else $error("unresolved record with zero count");

endmodule

bind call_latency_tracker clt_checker u_clt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_completed        (out_completed),
  .out_duration_ns      (out_duration_ns),
  .out_completed_count  (out_completed_count),
  .out_unresolved_total (out_unresolved_total),
  .out_call_number      (out_call_number)
);
